// ----- sv/timer_bank_one_shot_periodic_assert.svh -----
// Assertion macros shared by the timer bank checker.
`ifndef TIMER_BANK_ONE_SHOT_PERIODIC_ASSERT_SVH
`define TIMER_BANK_ONE_SHOT_PERIODIC_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define TBOP_ASSERT_NOW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error("tbop check failed");

// Next-cycle implication, sampled on the rising clock edge
`define TBOP_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("tbop check failed");

`endif

// ----- sv/tbop_pkg.sv -----
// Shared types and constants of the timer bank.
package tbop_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int Q_DEPTH        = 2;

    // opcodes of an input word
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_STOP   = 3'd2;
    localparam logic [2:0] OP_RESET  = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;
    localparam logic [2:0] OP_STATS  = 3'd6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef enum logic [2:0] {
        K_CREATE, K_START, K_STOP, K_RESET, K_TICK, K_QUERY, K_STATS, K_NOP
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE, S_READ, S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  timer_id;
        logic [31:0] period;
        logic        auto_reload;
    } t_in;

    typedef struct packed {
        logic [3:0]  new_id;
        logic        create_ok;
        logic        was_expired;
        logic [4:0]  total_timers;
        logic [4:0]  running_timers;
        logic [4:0]  stopped_timers;
        logic [4:0]  periodic_timers;
        logic [4:0]  one_shot_timers;
        logic [31:0] expire_total;
        logic [31:0] start_total;
    } t_out;

    // classified word handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  timer_id;
        logic [31:0] period;
        logic        auto_reload;
    } t_work;

    // one timer slot as stored in RAM
    typedef struct packed {
        logic [31:0] period;
        logic [31:0] left;
        logic [31:0] fired;
        logic [31:0] started;
        logic        reload;
        logic        running;
        logic        expired;
    } t_rec;

endpackage

// ----- sv/tbop_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tbop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tbop_front.sv -----
// Front end: accepts input words, classifies the opcode, queues them.
module tbop_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tbop_pkg::t_in       i_item,
    output logic                o_full,
    output logic                o_vld,
    input  logic                i_pop,
    output tbop_pkg::t_work     o_work
);

    localparam int PW = (tbop_pkg::Q_DEPTH > 1) ? $clog2(tbop_pkg::Q_DEPTH) : 1;
    localparam int CW = $clog2(tbop_pkg::Q_DEPTH + 1);

    tbop_pkg::t_work r_q [tbop_pkg::Q_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    tbop_pkg::t_work n_work;
    logic            w_push, w_pop;

    // opcode classification
    always_comb begin
        n_work.timer_id    = i_item.timer_id;
        n_work.period      = i_item.period;
        n_work.auto_reload = i_item.auto_reload;
        case (i_item.opcode)
            tbop_pkg::OP_CREATE: n_work.kind = tbop_pkg::K_CREATE;
            tbop_pkg::OP_START:  n_work.kind = tbop_pkg::K_START;
            tbop_pkg::OP_STOP:   n_work.kind = tbop_pkg::K_STOP;
            tbop_pkg::OP_RESET:  n_work.kind = tbop_pkg::K_RESET;
            tbop_pkg::OP_TICK:   n_work.kind = tbop_pkg::K_TICK;
            tbop_pkg::OP_QUERY:  n_work.kind = tbop_pkg::K_QUERY;
            tbop_pkg::OP_STATS:  n_work.kind = tbop_pkg::K_STATS;
            default:             n_work.kind = tbop_pkg::K_NOP;
        endcase
    end

    assign o_full = (r_cnt == CW'(tbop_pkg::Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_vld;
    assign o_work = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= n_work;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(tbop_pkg::Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(tbop_pkg::Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- sv/tbop_back.sv -----
// Back end: executes queued words against the timer slot RAM.
module tbop_back #(
    parameter int NUM_TIMERS = tbop_pkg::NUM_TIMERS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  tbop_pkg::t_work i_work,
    output logic            o_pop,
    input  logic            i_out_free,
    output logic            o_res_we,
    output tbop_pkg::t_out  o_res
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int RW = $bits(tbop_pkg::t_rec);

    tbop_pkg::t_state r_state, n_state;
    tbop_pkg::t_kind  r_kind;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_made, n_made;
    logic [4:0]       r_run, r_stop, r_prd, r_one;
    logic [4:0]       n_run, n_stop, n_prd, n_one;
    tbop_pkg::t_kind  n_kind;

    logic             w_we;
    logic [IW-1:0]    w_waddr;
    tbop_pkg::t_rec   w_wrec, w_rrec;
    logic [RW-1:0]    w_rdata;
    logic             w_id_ok, w_walk, w_last, w_start;
    logic [31:0]      w_left;

    tbop_ram #(.WIDTH(RW), .DEPTH(NUM_TIMERS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wrec),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rrec  = tbop_pkg::t_rec'(w_rdata);
    assign w_id_ok = (i_work.timer_id < 8'(r_made));
    assign w_start = (r_state == tbop_pkg::S_IDLE) && i_vld && i_out_free;
    assign w_walk  = (r_kind == tbop_pkg::K_TICK) || (r_kind == tbop_pkg::K_STATS);
    assign w_last  = !w_walk || (r_idx == IW'(r_made - CW'(1)));
    assign o_pop   = w_start;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbop_pkg::S_IDLE: begin
                if (w_start) begin
                    case (i_work.kind)
                        tbop_pkg::K_START, tbop_pkg::K_STOP,
                        tbop_pkg::K_RESET, tbop_pkg::K_QUERY: begin
                            if (w_id_ok) n_state = tbop_pkg::S_READ;
                        end
                        tbop_pkg::K_TICK, tbop_pkg::K_STATS: begin
                            if (r_made != '0) n_state = tbop_pkg::S_READ;
                        end
                        default: n_state = tbop_pkg::S_IDLE;
                    endcase
                end
            end
            tbop_pkg::S_READ: n_state = tbop_pkg::S_EXEC;
            tbop_pkg::S_EXEC: n_state = w_last ? tbop_pkg::S_IDLE : tbop_pkg::S_READ;
            default:          n_state = tbop_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM write and result
    always_comb begin
        n_kind   = r_kind;
        n_idx    = r_idx;
        n_made   = r_made;
        n_run    = r_run;
        n_stop   = r_stop;
        n_prd    = r_prd;
        n_one    = r_one;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wrec   = w_rrec;
        w_left   = '0;
        o_res_we = 1'b0;
        o_res    = '0;
        case (r_state)
            tbop_pkg::S_IDLE: begin
                if (w_start) begin
                    n_kind = i_work.kind;
                    n_idx  = i_work.timer_id[IW-1:0];
                    n_run  = '0;
                    n_stop = '0;
                    n_prd  = '0;
                    n_one  = '0;
                    case (i_work.kind)
                        tbop_pkg::K_CREATE: begin
                            o_res_we = 1'b1;
                            if (r_made < CW'(NUM_TIMERS)) begin
                                w_we           = 1'b1;
                                w_waddr        = r_made[IW-1:0];
                                w_wrec         = '0;
                                w_wrec.period  = i_work.period;
                                w_wrec.left    = i_work.period;
                                w_wrec.reload  = i_work.auto_reload;
                                n_made         = r_made + CW'(1);
                                o_res.new_id   = 4'(r_made);
                                o_res.create_ok = 1'b1;
                            end
                        end
                        tbop_pkg::K_START, tbop_pkg::K_STOP,
                        tbop_pkg::K_RESET, tbop_pkg::K_QUERY: begin
                            o_res_we = !w_id_ok;
                        end
                        tbop_pkg::K_TICK, tbop_pkg::K_STATS: begin
                            n_idx    = '0;
                            o_res_we = (r_made == '0);
                        end
                        default: o_res_we = 1'b1;
                    endcase
                end
            end
            tbop_pkg::S_EXEC: begin
                o_res_we = w_last;
                n_idx    = r_idx + IW'(1);
                case (r_kind)
                    tbop_pkg::K_START: begin
                        w_we           = 1'b1;
                        w_wrec.running = 1'b1;
                        w_wrec.expired = 1'b0;
                        w_wrec.left    = w_rrec.period;
                        w_wrec.started = w_rrec.started + 32'd1;
                    end
                    tbop_pkg::K_STOP: begin
                        w_we           = 1'b1;
                        w_wrec.running = 1'b0;
                    end
                    tbop_pkg::K_RESET: begin
                        w_we           = 1'b1;
                        w_wrec.left    = w_rrec.period;
                        w_wrec.expired = 1'b0;
                    end
                    tbop_pkg::K_QUERY: begin
                        w_we               = 1'b1;
                        w_wrec.expired     = 1'b0;
                        o_res.was_expired  = w_rrec.expired;
                        o_res.expire_total = w_rrec.fired;
                        o_res.start_total  = w_rrec.started;
                    end
                    tbop_pkg::K_TICK: begin
                        // count down, expire at zero, then reload or stop
                        w_left = (w_rrec.left != '0) ? w_rrec.left - 32'd1 : w_rrec.left;
                        if (w_rrec.running) begin
                            w_we        = 1'b1;
                            w_wrec.left = w_left;
                            if (w_left == '0) begin
                                w_wrec.expired = 1'b1;
                                w_wrec.fired   = w_rrec.fired + 32'd1;
                                if (w_rrec.reload) begin
                                    w_wrec.left = w_rrec.period;
                                end else begin
                                    w_wrec.running = 1'b0;
                                end
                            end
                        end
                    end
                    tbop_pkg::K_STATS: begin
                        n_run  = r_run + 5'(w_rrec.running);
                        n_stop = r_stop + 5'(!w_rrec.running);
                        n_prd  = r_prd + 5'(w_rrec.reload);
                        n_one  = r_one + 5'(!w_rrec.reload);
                        o_res.total_timers    = 5'(r_made);
                        o_res.running_timers  = n_run;
                        o_res.stopped_timers  = n_stop;
                        o_res.periodic_timers = n_prd;
                        o_res.one_shot_timers = n_one;
                    end
                    default: w_we = 1'b0;
                endcase
            end
            default: w_we = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbop_pkg::S_IDLE;
            r_made  <= '0;
        end else begin
            r_state <= n_state;
            r_made  <= n_made;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_idx  <= n_idx;
        r_run  <= n_run;
        r_stop <= n_stop;
        r_prd  <= n_prd;
        r_one  <= n_one;
    end

endmodule

// ----- sv/timer_bank_one_shot_periodic.sv -----
// Create, unused opcodes and invalid ids give their result without a RAM read.
// Start, stop, reset and query: one RAM read and one write-back of the slot.
// Tick and statistics: one read/modify/write of each created slot in turn
// on the one-read one-write slot RAM; words are executed one at a time behind a 2-word queue.
// Reset clears the queue, result register and created count; slot RAM needs no
// clearing since create writes the whole slot before it can be addressed.
module timer_bank_one_shot_periodic #(
    parameter int NUM_TIMERS = tbop_pkg::NUM_TIMERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  tbop_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output tbop_pkg::t_out o_result
);

    tbop_pkg::t_work w_work;
    tbop_pkg::t_out  w_res;
    logic            w_vld, w_qpop, w_res_we, w_out_free;
    logic            r_out_vld;
    tbop_pkg::t_out  r_out;

    tbop_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_vld   (w_vld),
        .i_pop   (w_qpop),
        .o_work  (w_work)
    );

    tbop_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_vld),
        .i_work     (w_work),
        .o_pop      (w_qpop),
        .i_out_free (w_out_free),
        .o_res_we   (w_res_we),
        .o_res      (w_res)
    );

    assign w_out_free = !r_out_vld || pop;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_we) begin
            r_out_vld <= 1'b1;
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_we) begin
            r_out <= w_res;
        end
    end

    assign empty    = !r_out_vld;
    assign o_result = r_out;

endmodule

// ----- sv/tbop_check.sv -----
// Port-level checker for the timer bank, bound to the top level.
`include "timer_bank_one_shot_periodic_assert.svh"

module tbop_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           push,
    input logic           full,
    input tbop_pkg::t_in  i_item,
    input logic           empty,
    input logic           pop,
    input tbop_pkg::t_out o_result
);

    `TBOP_ASSERT_NEXT(a_reset_clear, i_clk, !i_rst_n, empty && !full)
    `TBOP_ASSERT_NOW(a_create_clean, i_clk, i_rst_n && !empty && o_result.create_ok, o_result.total_timers == 5'd0 && !o_result.was_expired && o_result.start_total == 32'd0)
    `TBOP_ASSERT_NOW(a_stats_sum, i_clk, i_rst_n && !empty, 5'(o_result.running_timers + o_result.stopped_timers) == o_result.total_timers && 5'(o_result.periodic_timers + o_result.one_shot_timers) == o_result.total_timers)
    `TBOP_ASSERT_NEXT(a_hold, i_clk, i_rst_n && !empty && !pop, !i_rst_n || (!empty && $stable(o_result)))

endmodule

bind timer_bank_one_shot_periodic tbop_check u_check (.*);
